// ----- hw/rtl/bpdc_pkg.sv -----
package bpdc_pkg;

   localparam int CNT_W = 16;
   localparam int ADC_W = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int PHASE_CODE_W = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PRESS_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM_PRESS_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_SLEEP_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_TICKS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_HIGH     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_MID      = 3'd6;

   // phase codes as seen on the result channel
   localparam logic [PHASE_CODE_W-1:0] CODE_SLEEP    = 3'd0;
   localparam logic [PHASE_CODE_W-1:0] CODE_DEBOUNCE = 3'd1;
   localparam logic [PHASE_CODE_W-1:0] CODE_PRESS    = 3'd2;
   localparam logic [PHASE_CODE_W-1:0] CODE_BATTERY  = 3'd3;
   localparam logic [PHASE_CODE_W-1:0] CODE_WIFI     = 3'd4;
   localparam logic [PHASE_CODE_W-1:0] CODE_LONG     = 3'd5;
   localparam logic [PHASE_CODE_W-1:0] CODE_GOSLEEP  = 3'd6;

   typedef enum logic [6:0] {
      PH_SLEEP    = 7'b0000001,
      PH_DEBOUNCE = 7'b0000010,
      PH_PRESS    = 7'b0000100,
      PH_BATTERY  = 7'b0001000,
      PH_WIFI     = 7'b0010000,
      PH_LONG     = 7'b0100000,
      PH_GOSLEEP  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic main;
      logic red;
      logic green;
      logic blue;
   } leds_type;

   function automatic logic [PHASE_CODE_W-1:0] phase_code(input phase_type ph);
      logic [PHASE_CODE_W-1:0] code;
      case (ph)
         PH_SLEEP:    code = CODE_SLEEP;
         PH_DEBOUNCE: code = CODE_DEBOUNCE;
         PH_PRESS:    code = CODE_PRESS;
         PH_BATTERY:  code = CODE_BATTERY;
         PH_WIFI:     code = CODE_WIFI;
         PH_LONG:     code = CODE_LONG;
         PH_GOSLEEP:  code = CODE_GOSLEEP;
         default:     code = CODE_SLEEP;
      endcase
      return code;
   endfunction

endpackage

// ----- hw/rtl/button_press_duration_classifier.sv -----
// Button press duration classifier.
// Requests arrive on req_ (tvalid/tready/tdata), one per poll step, carrying
// the button edge flag, the timer tick, the button level and an ADC sample.
// Each request yields exactly one response on rsp_: the phase code, the four
// LED levels and the tick counter as they stand after that step.
// Registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while idle, the block does not enforce it. Throughput: one
// request per cycle unless rsp_tready stalls; each step is a single pass of
// compares and counter updates between the input and response registers.
// Blink tests use one residue counter per blink period that follows the tick
// counter, so no divider sits in the path.
// Reset: phase sleep, counter and timer cleared, block armed, LEDs off,
// registers at their default values, both pipeline registers empty.
// Stall: while rsp_tready is low the response register holds; one more
// request can be taken into the input register, then req_tready drops.
module button_press_duration_classifier #(
   parameter int PRESS_BLINK_PERIOD = 50,
   parameter int HIGH_BLINK_PERIOD  = 10,
   parameter int MID_BLINK_PERIOD   = 20,
   parameter int LOW_BLINK_PERIOD   = 40,
   parameter int ADC_BITS           = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // button_edge, tick, button_level, adc_sample[11:0], zero fill
   input  logic [bpdc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // phase_code[2:0], main_led, red_led, green_led, blue_led,
   // elapsed_ticks[15:0], zero fill
   output logic [bpdc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_we,
   input  logic [bpdc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpdc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW = bpdc_pkg::CNT_W;
   localparam int AW = bpdc_pkg::ADC_W;
   localparam int AdcKeep = (ADC_BITS < AW) ? ADC_BITS : AW;
   localparam logic [AW-1:0] AdcMask = AW'((32'd1 << AdcKeep) - 32'd1);
   localparam logic [CW-1:0] PressLast = CW'(PRESS_BLINK_PERIOD - 1);
   localparam logic [CW-1:0] HighLast  = CW'(HIGH_BLINK_PERIOD - 1);
   localparam logic [CW-1:0] MidLast   = CW'(MID_BLINK_PERIOD - 1);
   localparam logic [CW-1:0] LowLast   = CW'(LOW_BLINK_PERIOD - 1);
   localparam logic [CW-1:0] CntMax    = '1;

   function automatic logic [CW-1:0] res_step(input logic [CW-1:0] r,
                                              input logic [CW-1:0] last);
      return (r == last) ? '0 : r + CW'(1);
   endfunction

   // configuration registers
   logic [CW-1:0] debounce_ticks_ff, short_press_max_ff, medium_press_max_ff;
   logic [CW-1:0] hold_sleep_ticks_ff, display_ticks_ff;
   logic [AW-1:0] battery_high_ff, battery_mid_ff;

   // block state
   bpdc_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                armed_ff, armed_in;
   logic [AW-1:0]       level_ff, level_in;
   bpdc_pkg::leds_type  leds_ff, leds_in;
   logic [CW-1:0]       r_press_ff, r_press_in, r_high_ff, r_high_in;
   logic [CW-1:0]       r_mid_ff, r_mid_in, r_low_ff, r_low_in;

   // pipeline registers
   logic                s1_valid_ff;
   logic                s1_edge_ff, s1_tick_ff, s1_held_ff;
   logic [AW-1:0]       s1_sample_ff;
   logic                out_valid_ff;
   logic [bpdc_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic advance;
   logic clear_cnt;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= CW'(2);
         short_press_max_ff  <= CW'(100);
         medium_press_max_ff <= CW'(300);
         hold_sleep_ticks_ff <= CW'(500);
         display_ticks_ff    <= CW'(300);
         battery_high_ff     <= AW'(3000);
         battery_mid_ff      <= AW'(2500);
      end else if (csr_we) begin
         case (csr_index)
            bpdc_pkg::CSR_DEBOUNCE_TICKS:   debounce_ticks_ff   <= csr_wdata;
            bpdc_pkg::CSR_SHORT_PRESS_MAX:  short_press_max_ff  <= csr_wdata;
            bpdc_pkg::CSR_MEDIUM_PRESS_MAX: medium_press_max_ff <= csr_wdata;
            bpdc_pkg::CSR_HOLD_SLEEP_TICKS: hold_sleep_ticks_ff <= csr_wdata;
            bpdc_pkg::CSR_DISPLAY_TICKS:    display_ticks_ff    <= csr_wdata;
            bpdc_pkg::CSR_BATTERY_HIGH:     battery_high_ff     <= csr_wdata[AW-1:0];
            bpdc_pkg::CSR_BATTERY_MID:      battery_mid_ff      <= csr_wdata[AW-1:0];
            default: ;
         endcase
      end
   end

   // one poll step
   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      run_in     = run_ff;
      armed_in   = armed_ff;
      level_in   = level_ff;
      leds_in    = leds_ff;
      r_press_in = r_press_ff;
      r_high_in  = r_high_ff;
      r_mid_in   = r_mid_ff;
      r_low_in   = r_low_ff;
      clear_cnt  = 1'b0;

      if (s1_edge_ff) begin
         leds_in.main = 1'b1;
         phase_in     = bpdc_pkg::PH_DEBOUNCE;
         armed_in     = 1'b1;
      end
      if (s1_tick_ff && run_ff && cnt_ff != CntMax) begin
         cnt_in     = cnt_ff + CW'(1);
         r_press_in = res_step(r_press_ff, PressLast);
         r_high_in  = res_step(r_high_ff, HighLast);
         r_mid_in   = res_step(r_mid_ff, MidLast);
         r_low_in   = res_step(r_low_ff, LowLast);
      end

      case (phase_in)
         bpdc_pkg::PH_DEBOUNCE: begin
            if (cnt_in < debounce_ticks_ff) begin
               if (armed_in) begin
                  armed_in = 1'b0;
                  run_in   = 1'b1;
               end
            end else begin
               phase_in = bpdc_pkg::PH_PRESS;
            end
         end
         bpdc_pkg::PH_PRESS: begin
            if (s1_held_ff) begin
               if (s1_tick_ff && r_press_in == '0) leds_in.main = !leds_in.main;
               if (cnt_in > hold_sleep_ticks_ff) phase_in = bpdc_pkg::PH_GOSLEEP;
            end else begin
               run_in       = 1'b0;
               leds_in.main = 1'b0;
               if (cnt_in <= short_press_max_ff) phase_in = bpdc_pkg::PH_BATTERY;
               else if (cnt_in <= medium_press_max_ff) phase_in = bpdc_pkg::PH_WIFI;
               else phase_in = bpdc_pkg::PH_LONG;
               armed_in  = 1'b1;
               clear_cnt = 1'b1;
            end
         end
         bpdc_pkg::PH_BATTERY: begin
            if (armed_in) begin
               level_in = s1_sample_ff & AdcMask;
               run_in   = 1'b1;
               armed_in = 1'b0;
            end
            if (s1_tick_ff) begin
               if (level_in >= battery_high_ff) begin
                  if (r_high_in == '0) leds_in.green = !leds_in.green;
               end else if (level_in >= battery_mid_ff) begin
                  if (r_mid_in == '0) leds_in.blue = !leds_in.blue;
               end else begin
                  if (r_low_in == '0) leds_in.red = !leds_in.red;
               end
            end
            if (cnt_in >= display_ticks_ff) begin
               phase_in  = bpdc_pkg::PH_SLEEP;
               run_in    = 1'b0;
               clear_cnt = 1'b1;
            end
         end
         bpdc_pkg::PH_WIFI: phase_in = bpdc_pkg::PH_GOSLEEP;
         bpdc_pkg::PH_LONG: begin
            leds_in.main = 1'b1;
            run_in       = 1'b1;
            armed_in     = 1'b0;
            if (cnt_in >= display_ticks_ff) begin
               phase_in  = bpdc_pkg::PH_SLEEP;
               run_in    = 1'b0;
               clear_cnt = 1'b1;
            end
         end
         bpdc_pkg::PH_GOSLEEP: begin
            phase_in     = bpdc_pkg::PH_SLEEP;
            run_in       = 1'b0;
            clear_cnt    = 1'b1;
            leds_in.main = 1'b0;
         end
         default: ;
      endcase

      if (clear_cnt) begin
         cnt_in     = '0;
         r_press_in = '0;
         r_high_in  = '0;
         r_mid_in   = '0;
         r_low_in   = '0;
      end

      out_data_in = {1'b0, cnt_in, leds_in.blue, leds_in.green, leds_in.red,
                     leds_in.main, bpdc_pkg::phase_code(phase_in)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bpdc_pkg::PH_SLEEP;
         cnt_ff     <= '0;
         run_ff     <= 1'b0;
         armed_ff   <= 1'b1;
         level_ff   <= '0;
         leds_ff    <= '0;
         r_press_ff <= '0;
         r_high_ff  <= '0;
         r_mid_ff   <= '0;
         r_low_ff   <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         run_ff     <= run_in;
         armed_ff   <= armed_in;
         level_ff   <= level_in;
         leds_ff    <= leds_in;
         r_press_ff <= r_press_in;
         r_high_ff  <= r_high_in;
         r_mid_ff   <= r_mid_in;
         r_low_ff   <= r_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) s1_valid_ff <= req_tvalid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_edge_ff   <= req_tdata[0];
         s1_tick_ff   <= req_tdata[1];
         s1_held_ff   <= req_tdata[2];
         s1_sample_ff <= req_tdata[AW+2:3];
      end
      if (advance) out_data_ff <= out_data_in;
   end

   // residues never reach their period
   assert property (@(posedge clock) disable iff (reset)
      r_press_ff <= PressLast && r_high_ff <= HighLast &&
      r_mid_ff <= MidLast && r_low_ff <= LowLast)
      else $error("blink residue out of range");

   // a cleared counter has all residues cleared
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> (r_press_ff == '0 && r_high_ff == '0 &&
                        r_mid_ff == '0 && r_low_ff == '0))
      else $error("blink residue out of step with counter");

   // sleep always has the timer stopped and the counter cleared
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == bpdc_pkg::PH_SLEEP |-> (!run_ff && cnt_ff == '0))
      else $error("sleep with timer running or counter set");

   // a loaded response shows the state that the step left
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(advance)) |->
         (rsp_tdata[bpdc_pkg::PHASE_CODE_W-1:0] == bpdc_pkg::phase_code(phase_ff) &&
          rsp_tdata[CW+6:7] == cnt_ff))
      else $error("response differs from block state");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int PRESS_BLINK_PERIOD = 50;
   localparam int HIGH_BLINK_PERIOD  = 10;
   localparam int MID_BLINK_PERIOD   = 20;
   localparam int LOW_BLINK_PERIOD   = 40;
   localparam int ADC_BITS           = 12;

   localparam int NUM_CSRS         = 7;
   localparam int RANDOM_ITEMS     = 400;
   localparam int MAX_HOLD_ITEMS   = 30;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int MAX_REPORTS      = 10;
   localparam logic [bpdc_pkg::ADC_W-1:0] ADC_KEEP =
      bpdc_pkg::ADC_W'((32'd1 << ADC_BITS) - 32'd1);
   // one past the last register; writes here must change nothing
   localparam logic [bpdc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [bpdc_pkg::CNT_W-1:0]        elapsed;
      logic                              blue;
      logic                              green;
      logic                              red;
      logic                              main;
      logic [bpdc_pkg::PHASE_CODE_W-1:0] code;
   } poll_status_type;

   typedef logic [NUM_CSRS-1:0][bpdc_pkg::CSR_DATA_W-1:0] csr_set_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bpdc_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bpdc_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             csr_we     = 1'b0;
   logic [bpdc_pkg::CSR_IDX_W-1:0]   csr_index  = '0;
   logic [bpdc_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   // predictor state
   logic [bpdc_pkg::CSR_DATA_W-1:0]   csr_shadow [NUM_CSRS];
   logic [bpdc_pkg::PHASE_CODE_W-1:0] ph_code;
   logic [bpdc_pkg::CNT_W-1:0]        tick_cnt;
   logic                              timer_on;
   logic                              rearm;
   logic [bpdc_pkg::ADC_W-1:0]        batt_level;
   bpdc_pkg::leds_type                led_state;

   poll_status_type expected_status [$];
   int gap_pct     = 27;
   int stall_pct   = 77;
   int items_sent  = 0;
   int fail_count  = 0;
   int cycle_count = 0;

   button_press_duration_classifier #(
      .PRESS_BLINK_PERIOD(PRESS_BLINK_PERIOD),
      .HIGH_BLINK_PERIOD (HIGH_BLINK_PERIOD),
      .MID_BLINK_PERIOD  (MID_BLINK_PERIOD),
      .LOW_BLINK_PERIOD  (LOW_BLINK_PERIOD),
      .ADC_BITS          (ADC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic void reset_model();
      csr_shadow[bpdc_pkg::CSR_DEBOUNCE_TICKS]   = 16'd2;
      csr_shadow[bpdc_pkg::CSR_SHORT_PRESS_MAX]  = 16'd100;
      csr_shadow[bpdc_pkg::CSR_MEDIUM_PRESS_MAX] = 16'd300;
      csr_shadow[bpdc_pkg::CSR_HOLD_SLEEP_TICKS] = 16'd500;
      csr_shadow[bpdc_pkg::CSR_DISPLAY_TICKS]    = 16'd300;
      csr_shadow[bpdc_pkg::CSR_BATTERY_HIGH]     = 16'd3000;
      csr_shadow[bpdc_pkg::CSR_BATTERY_MID]      = 16'd2500;
      ph_code    = bpdc_pkg::CODE_SLEEP;
      tick_cnt   = '0;
      timer_on   = 1'b0;
      rearm      = 1'b1;
      batt_level = '0;
      led_state  = '0;
   endfunction

   function automatic void shadow_write(input logic [bpdc_pkg::CSR_IDX_W-1:0] idx,
                                        input logic [bpdc_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         bpdc_pkg::CSR_BATTERY_HIGH, bpdc_pkg::CSR_BATTERY_MID: begin
            csr_shadow[idx] = {{(bpdc_pkg::CSR_DATA_W-bpdc_pkg::ADC_W){1'b0}},
                               value[bpdc_pkg::ADC_W-1:0]};
         end
         CSR_UNUSED: begin
         end
         default: begin
            csr_shadow[idx] = value;
         end
      endcase
   endfunction

   function automatic void enter_sleep();
      ph_code  = bpdc_pkg::CODE_SLEEP;
      timer_on = 1'b0;
      tick_cnt = '0;
   endfunction

   // One poll step: edge first, then the tick, then the current phase.
   function automatic poll_status_type classify_poll(input logic btn_edge,
                                                     input logic tick_in,
                                                     input logic held,
                                                     input logic [bpdc_pkg::ADC_W-1:0] adc);
      poll_status_type st;
      if (btn_edge) begin
         led_state.main = 1'b1;
         ph_code        = bpdc_pkg::CODE_DEBOUNCE;
         rearm          = 1'b1;
      end
      if (tick_in && timer_on && tick_cnt != '1)
         tick_cnt = tick_cnt + 1'b1;

      case (ph_code)
         bpdc_pkg::CODE_DEBOUNCE: begin
            if (tick_cnt < csr_shadow[bpdc_pkg::CSR_DEBOUNCE_TICKS]) begin
               if (rearm) begin
                  rearm    = 1'b0;
                  timer_on = 1'b1;
               end
            end else begin
               ph_code = bpdc_pkg::CODE_PRESS;
            end
         end
         bpdc_pkg::CODE_PRESS: begin
            if (held) begin
               if (tick_in && (tick_cnt % PRESS_BLINK_PERIOD) == 0)
                  led_state.main = ~led_state.main;
               if (tick_cnt > csr_shadow[bpdc_pkg::CSR_HOLD_SLEEP_TICKS])
                  ph_code = bpdc_pkg::CODE_GOSLEEP;
            end else begin
               timer_on       = 1'b0;
               led_state.main = 1'b0;
               if (tick_cnt <= csr_shadow[bpdc_pkg::CSR_SHORT_PRESS_MAX])
                  ph_code = bpdc_pkg::CODE_BATTERY;
               else if (tick_cnt <= csr_shadow[bpdc_pkg::CSR_MEDIUM_PRESS_MAX])
                  ph_code = bpdc_pkg::CODE_WIFI;
               else
                  ph_code = bpdc_pkg::CODE_LONG;
               rearm    = 1'b1;
               tick_cnt = '0;
            end
         end
         bpdc_pkg::CODE_BATTERY: begin
            if (rearm) begin
               batt_level = adc & ADC_KEEP;
               timer_on   = 1'b1;
               rearm      = 1'b0;
            end
            if (tick_in) begin
               if (batt_level >= csr_shadow[bpdc_pkg::CSR_BATTERY_HIGH]) begin
                  if ((tick_cnt % HIGH_BLINK_PERIOD) == 0)
                     led_state.green = ~led_state.green;
               end else if (batt_level >= csr_shadow[bpdc_pkg::CSR_BATTERY_MID]) begin
                  if ((tick_cnt % MID_BLINK_PERIOD) == 0)
                     led_state.blue = ~led_state.blue;
               end else begin
                  if ((tick_cnt % LOW_BLINK_PERIOD) == 0)
                     led_state.red = ~led_state.red;
               end
            end
            if (tick_cnt >= csr_shadow[bpdc_pkg::CSR_DISPLAY_TICKS])
               enter_sleep();
         end
         bpdc_pkg::CODE_WIFI: begin
            ph_code = bpdc_pkg::CODE_GOSLEEP;
         end
         bpdc_pkg::CODE_LONG: begin
            led_state.main = 1'b1;
            timer_on       = 1'b1;
            rearm          = 1'b0;
            if (tick_cnt >= csr_shadow[bpdc_pkg::CSR_DISPLAY_TICKS])
               enter_sleep();
         end
         bpdc_pkg::CODE_GOSLEEP: begin
            enter_sleep();
            led_state.main = 1'b0;
         end
         default: begin
         end
      endcase

      st.code    = ph_code;
      st.main    = led_state.main;
      st.red     = led_state.red;
      st.green   = led_state.green;
      st.blue    = led_state.blue;
      st.elapsed = tick_cnt;
      return st;
   endfunction

   task automatic report_field(input string what, input int want, input int got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      poll_status_type got;
      poll_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = poll_status_type'(rsp_tdata[$bits(poll_status_type)-1:0]);
         if (expected_status.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("response 0x%h arrived with no request pending", rsp_tdata);
         end else begin
            want = expected_status.pop_front();
            report_field("phase_code", want.code, got.code);
            report_field("main_led", want.main, got.main);
            report_field("red_led", want.red, got.red);
            report_field("green_led", want.green, got.green);
            report_field("blue_led", want.blue, got.blue);
            report_field("elapsed_ticks", want.elapsed, got.elapsed);
         end
      end
   end

   // Enter and leave at a rising edge; returns at the edge that takes the request.
   task automatic send_poll(input logic btn_edge, input logic tick_in, input logic held,
                            input logic [bpdc_pkg::ADC_W-1:0] adc);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, adc, held, tick_in, btn_edge};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_status.push_back(classify_poll(btn_edge, tick_in, held, adc));
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_csrs(input csr_set_type vals);
      wait_for_results();
      for (int i = bpdc_pkg::CSR_DEBOUNCE_TICKS; i <= bpdc_pkg::CSR_BATTERY_MID; i++) begin
         csr_we    <= 1'b1;
         csr_index <= bpdc_pkg::CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         shadow_write(bpdc_pkg::CSR_IDX_W'(i), vals[i]);
         @(posedge clock);
      end
      csr_index <= CSR_UNUSED;
      csr_wdata <= bpdc_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic coin(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // Press, hold for a while, release and let the display run.
   task automatic press_cycle();
      int hold_lim;
      int show_lim;
      int tick_pct;
      logic [bpdc_pkg::ADC_W-1:0] adc_hold;
      hold_lim = int'(csr_shadow[bpdc_pkg::CSR_HOLD_SLEEP_TICKS]) + 6;
      show_lim = int'(csr_shadow[bpdc_pkg::CSR_DISPLAY_TICKS]) + 6;
      if (hold_lim > 120) hold_lim = 120;
      if (show_lim > 80) show_lim = 80;
      tick_pct = $urandom_range(50, 100);
      adc_hold = bpdc_pkg::ADC_W'($urandom);
      send_poll(1'b1, coin(tick_pct), 1'b1, bpdc_pkg::ADC_W'($urandom));
      repeat ($urandom_range(0, hold_lim))
         send_poll($urandom_range(0, 39) == 0, coin(tick_pct), 1'b1,
                   bpdc_pkg::ADC_W'($urandom));
      repeat ($urandom_range(0, show_lim))
         send_poll(1'b0, coin(tick_pct), 1'b0, adc_hold);
   endtask

   task automatic test_reset_defaults();
      send_poll(1'b0, 1'b1, 1'b1, '1);
      send_poll(1'b1, 1'b0, 1'b1, '0);
      send_poll(1'b0, 1'b1, 1'b1, '0);
      send_poll(1'b0, 1'b1, 1'b1, '0);
      send_poll(1'b0, 1'b1, 1'b1, '0);
      send_poll(1'b0, 1'b0, 1'b0, '0);
      send_poll(1'b0, 1'b1, 1'b0, '1);
      send_poll(1'b0, 1'b1, 1'b0, '0);
      // bounce while the battery display runs: counter carries over
      send_poll(1'b1, 1'b1, 1'b1, '0);
      send_poll(1'b0, 1'b0, 1'b0, '0);
   endtask

   task automatic test_phase_walk();
      csr_set_type vals;
      vals[bpdc_pkg::CSR_DEBOUNCE_TICKS]   = 16'd1;
      vals[bpdc_pkg::CSR_SHORT_PRESS_MAX]  = 16'd1;
      vals[bpdc_pkg::CSR_MEDIUM_PRESS_MAX] = 16'd2;
      vals[bpdc_pkg::CSR_HOLD_SLEEP_TICKS] = 16'd3;
      vals[bpdc_pkg::CSR_DISPLAY_TICKS]    = 16'd2;
      vals[bpdc_pkg::CSR_BATTERY_HIGH]     = {4'($urandom), 12'd3000};
      vals[bpdc_pkg::CSR_BATTERY_MID]      = {4'($urandom), 12'd2000};
      load_csrs(vals);
      // short press: battery display, then sleep
      send_poll(1'b1, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b0, 1'b0, bpdc_pkg::ADC_W'($urandom));
      repeat (3) send_poll(1'b0, 1'b1, 1'b0, 12'd2400);
      // medium press: wifi falls through to gosleep
      send_poll(1'b1, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      repeat (2) send_poll(1'b0, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b0, 1'b0, bpdc_pkg::ADC_W'($urandom));
      repeat (2) send_poll(1'b0, 1'b0, 1'b0, bpdc_pkg::ADC_W'($urandom));
      // long press: long display runs out
      send_poll(1'b1, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      repeat (3) send_poll(1'b0, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b0, 1'b0, bpdc_pkg::ADC_W'($urandom));
      repeat (3) send_poll(1'b0, 1'b1, 1'b0, bpdc_pkg::ADC_W'($urandom));
      // held too long
      send_poll(1'b1, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      repeat (4) send_poll(1'b0, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b0, 1'b1, bpdc_pkg::ADC_W'($urandom));
   endtask

   task automatic test_zero_registers();
      csr_set_type vals;
      vals = '0;
      load_csrs(vals);
      // no debounce means the timer never starts; every tick blinks the press
      send_poll(1'b1, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b0, 1'b1, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b0, 1'b0, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b1, 1'b0, '0);
      send_poll(1'b0, 1'b0, 1'b0, bpdc_pkg::ADC_W'($urandom));
   endtask

   task automatic test_random_sequences();
      csr_set_type vals;
      int short_max;
      int medium_max;
      int target;
      int pick;
      for (int mode = 0; mode < 3; mode++) begin
         short_max  = $urandom_range(1, 15);
         medium_max = short_max + $urandom_range(1, 15);
         vals[bpdc_pkg::CSR_DEBOUNCE_TICKS]   =
            bpdc_pkg::CSR_DATA_W'($urandom_range(0, 4));
         vals[bpdc_pkg::CSR_SHORT_PRESS_MAX]  = bpdc_pkg::CSR_DATA_W'(short_max);
         vals[bpdc_pkg::CSR_MEDIUM_PRESS_MAX] = bpdc_pkg::CSR_DATA_W'(medium_max);
         vals[bpdc_pkg::CSR_HOLD_SLEEP_TICKS] =
            bpdc_pkg::CSR_DATA_W'(medium_max + $urandom_range(1, 40));
         vals[bpdc_pkg::CSR_DISPLAY_TICKS]    =
            bpdc_pkg::CSR_DATA_W'($urandom_range(4, 45));
         vals[bpdc_pkg::CSR_BATTERY_HIGH]     = {4'($urandom), 12'($urandom_range(2400, 3600))};
         vals[bpdc_pkg::CSR_BATTERY_MID]      = {4'($urandom), 12'($urandom_range(800, 2200))};
         load_csrs(vals);
         case (mode)
            0: begin gap_pct = 27; stall_pct = 77; end
            1: begin gap_pct = 77; stall_pct = 27; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         target = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               press_cycle();
            end else if (pick < 93) begin
               repeat ($urandom_range(1, 8))
                  send_poll(coin(25), coin(50), coin(50), bpdc_pkg::ADC_W'($urandom));
            end else begin
               // hold off until everything sent so far has come back
               wait_for_results();
            end
         end
      end
   endtask

   // All registers at their top value: long debounce, no class boundary reached.
   task automatic test_max_registers();
      csr_set_type vals;
      vals = '1;
      load_csrs(vals);
      gap_pct   = 0;
      stall_pct = 0;
      send_poll(1'b1, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      repeat (MAX_HOLD_ITEMS)
         send_poll(1'b0, 1'b1, 1'b1, bpdc_pkg::ADC_W'($urandom));
      send_poll(1'b0, 1'b1, 1'b0, bpdc_pkg::ADC_W'($urandom));
      repeat (3) send_poll(1'b0, 1'b1, 1'b0, '1);
   endtask

   initial begin
      reset_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_phase_walk();
      test_zero_registers();
      test_random_sequences();
      test_max_registers();
      wait_for_results();
      if (fail_count == 0 && expected_status.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- button_press_duration_classifier.f -----
hw/rtl/bpdc_pkg.sv
hw/rtl/button_press_duration_classifier.sv
sim/tb.sv
